@@ hw/rtl/double_ended_priority_queue_top_assert.svh @@
// Assertion macros for the double-ended priority queue.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DEPQ_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("depq check failed");
`define DEPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("depq check failed");
`else
`define DEPQ_ASSERT(lbl, expr)
`define DEPQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/depq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package depq_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int OP_W         = 2;
  localparam int ID_W         = 20;
  localparam int PRIO_W       = 24;
  localparam int ST_W         = 2;
  localparam int OCC_W        = 11;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_POP_HI = 2'd1,
    OP_POP_LO = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_POP_HI,
    CMD_POP_LO
  } kind_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } slot_t;

  typedef struct packed {
    kind_t             kind;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/depq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module depq_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  depq_pkg::cmd_t  cmd,
  input  depq_pkg::slot_t left,
  input  logic            left_ge,
  input  depq_pkg::slot_t right,
  output depq_pkg::slot_t slot_q,
  output logic            ge
);

  logic                        valid_r, valid_nxt;
  logic [depq_pkg::PRIO_W-1:0] prio_r, prio_nxt;
  logic [depq_pkg::ID_W-1:0]   id_r, id_nxt;

  assign ge     = !valid_r || (prio_r >= cmd.prio);
  assign slot_q = '{valid: valid_r, prio: prio_r, id: id_r};

  always_comb begin
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    id_nxt    = id_r;
    case (cmd.kind)
      depq_pkg::CMD_INSERT: begin
        if (ge && left_ge) begin
          valid_nxt = left.valid;
          prio_nxt  = left.prio;
          id_nxt    = left.id;
        end else if (ge) begin
          valid_nxt = 1'b1;
          prio_nxt  = cmd.prio;
          id_nxt    = cmd.id;
        end
      end
      depq_pkg::CMD_POP_LO: begin
        valid_nxt = right.valid;
        prio_nxt  = right.prio;
        id_nxt    = right.id;
      end
      depq_pkg::CMD_POP_HI: begin
        valid_nxt = valid_r && right.valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    id_r   <= id_nxt;
  end

endmodule
`default_nettype wire

@@ hw/rtl/depq_or_tree.sv @@
`timescale 1ns / 1ps
`default_nettype none
module depq_or_tree #(
  parameter int N = depq_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  input  logic [N-1:0][depq_pkg::ID_W-1:0]   leaves,
  output logic                               out_vld,
  output logic [depq_pkg::ID_W-1:0]          out_id
);

  localparam int W     = depq_pkg::ID_W;
  localparam int LVL   = ($clog2(N) + 3) / 4;
  localparam int PAD   = 1 << (4 * LVL);
  localparam int NODES = PAD / 16;

  logic [W-1:0]   node_r [LVL][NODES];
  logic [LVL-1:0] vld_r;

  for (genvar k = 0; k < LVL; k++) begin : g_lvl
    localparam int CNT = PAD >> (4 * (k + 1));
    for (genvar j = 0; j < NODES; j++) begin : g_node
      if (j < CNT) begin : g_used
        logic [W-1:0] term [16];
        logic [W-1:0] sum;
        for (genvar m = 0; m < 16; m++) begin : g_term
          if (k == 0) begin : g_leaf
            if (j * 16 + m < N) begin : g_real
              assign term[m] = leaves[j * 16 + m];
            end else begin : g_pad
              assign term[m] = '0;
            end
          end else begin : g_inner
            assign term[m] = node_r[k-1][j * 16 + m];
          end
        end
        always_comb begin
          sum = '0;
          for (int m = 0; m < 16; m++) begin
            sum = sum | term[m];
          end
        end
        always_ff @(posedge clk) begin
          node_r[k][j] <= sum;
        end
      end else begin : g_unused
        always_ff @(posedge clk) begin
          node_r[k][j] <= '0;
        end
      end
    end
  end

  if (LVL == 1) begin : g_vld_one
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= '0;
      end else begin
        vld_r <= in_vld;
      end
    end
  end else begin : g_vld_many
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= '0;
      end else begin
        vld_r <= {vld_r[LVL-2:0], in_vld};
      end
    end
  end

  assign out_vld = vld_r[LVL-1];
  assign out_id  = node_r[LVL-1][0];

endmodule
`default_nettype wire

@@ hw/rtl/double_ended_priority_queue_top.sv @@
// An accepted request passes through the registered levels of the 16-way OR
// tree that gathers the id of the highest entry out of the cell chain, then
// through the output register, before the result word strobes. The block
// takes no new request while busy, that is until the tree has delivered it.
// The receiver cannot stall. Synchronous active-low reset clears the valid bit
// of every cell, the entry count and the pipeline.
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_priority_queue_top_assert.svh"
module double_ended_priority_queue_top #(
  parameter int CAPACITY = depq_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [depq_pkg::OP_W-1:0]    in_operation,
  input  logic [depq_pkg::ID_W-1:0]    in_client_id,
  input  logic [depq_pkg::PRIO_W-1:0]  in_priority_req,
  output logic                         out_strobe,
  output logic [depq_pkg::ID_W-1:0]    out_popped_id,
  output logic [depq_pkg::ST_W-1:0]    out_status,
  output logic [depq_pkg::OCC_W-1:0]   out_occupancy
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic                                   accept;
  logic                                   insert_acc;
  logic                                   busy_r;
  logic [CW-1:0]                          count_r, count_nxt;
  depq_pkg::cmd_t                         cmd;
  depq_pkg::status_t                      status_nxt, status_r;
  depq_pkg::kind_t                        kind_r;
  logic [depq_pkg::ID_W-1:0]              lo_id_r;
  logic [CW-1:0]                          occ_r;
  depq_pkg::slot_t                        slot_q [CAPACITY];
  logic                                   ge [CAPACITY];
  logic [CAPACITY-1:0]                    valid_vec;
  logic [CAPACITY-1:0][depq_pkg::ID_W-1:0] leaf;
  logic                                   tree_vld;
  logic [depq_pkg::ID_W-1:0]              tree_id;
  logic                                   full, empty;
  logic                                   out_strobe_r;
  logic [depq_pkg::ID_W-1:0]              out_popped_id_r, popped_nxt;
  logic [depq_pkg::ST_W-1:0]              out_status_r;
  logic [depq_pkg::OCC_W-1:0]             out_occupancy_r;

  assign accept     = start && !busy_r;
  assign insert_acc = accept && (cmd.kind == depq_pkg::CMD_INSERT);
  assign busy       = busy_r;
  assign full       = (count_r == CW'(CAPACITY));
  assign empty      = (count_r == '0);

  always_comb begin
    cmd        = '{kind: depq_pkg::CMD_NONE, prio: in_priority_req, id: in_client_id};
    status_nxt = depq_pkg::ST_DONE;
    count_nxt  = count_r;
    if (accept) begin
      case (in_operation)
        depq_pkg::OP_INSERT: begin
          if (full) begin
            status_nxt = depq_pkg::ST_FULL;
          end else begin
            cmd.kind  = depq_pkg::CMD_INSERT;
            count_nxt = count_r + CW'(1);
          end
        end
        depq_pkg::OP_POP_HI: begin
          if (empty) begin
            status_nxt = depq_pkg::ST_EMPTY;
          end else begin
            cmd.kind  = depq_pkg::CMD_POP_HI;
            count_nxt = count_r - CW'(1);
          end
        end
        depq_pkg::OP_POP_LO: begin
          if (empty) begin
            status_nxt = depq_pkg::ST_EMPTY;
          end else begin
            cmd.kind  = depq_pkg::CMD_POP_LO;
            count_nxt = count_r - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    depq_pkg::slot_t left, right;
    logic            left_ge;
    if (i == 0) begin : g_first
      assign left    = '0;
      assign left_ge = 1'b0;
    end else begin : g_mid
      assign left    = slot_q[i-1];
      assign left_ge = ge[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_up
      assign right = slot_q[i+1];
    end
    depq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .left    (left),
      .left_ge (left_ge),
      .right   (right),
      .slot_q  (slot_q[i]),
      .ge      (ge[i])
    );
    assign valid_vec[i] = slot_q[i].valid;
    assign leaf[i]      = (slot_q[i].valid && !right.valid) ? slot_q[i].id : '0;
  end

  depq_or_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (accept),
    .leaves  (leaf),
    .out_vld (tree_vld),
    .out_id  (tree_id)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (tree_vld) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= depq_pkg::CMD_NONE;
    end else if (accept) begin
      kind_r <= cmd.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      lo_id_r  <= slot_q[0].id;
      occ_r    <= count_nxt;
    end
  end

  always_comb begin
    case (kind_r)
      depq_pkg::CMD_POP_HI: popped_nxt = tree_id;
      depq_pkg::CMD_POP_LO: popped_nxt = lo_id_r;
      default:              popped_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= tree_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (tree_vld) begin
      out_popped_id_r <= popped_nxt;
      out_status_r    <= status_r;
      out_occupancy_r <= depq_pkg::OCC_W'(occ_r);
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_popped_id = out_popped_id_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occupancy_r;

  `DEPQ_ASSERT(a_count_cap, count_r <= CW'(CAPACITY))
  `DEPQ_ASSERT(a_valid_matches_count, $countones(valid_vec) == int'(count_r))
  `DEPQ_ASSERT_NEXT(a_accept_busy, rst_n && accept, busy_r)
  `DEPQ_ASSERT_NEXT(a_insert_grows, rst_n && insert_acc, count_r == $past(count_r) + CW'(1))

endmodule
`default_nettype wire
